// ===== src/mvsd_pkg.sv =====
// Shared types, widths and constants for the light-to-servo moving average block.
package mvsd_pkg;

  // Field widths
  localparam int SAMPLE_W    = 12;
  localparam int ANGLE_W     = 8;
  localparam int PULSE_W     = 15;
  localparam int DUTY_W      = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 15;

  // Window defaults
  localparam int WINDOW_DEF = 10;
  localparam int SAMPLE_MAX = 4095;

  // Serial divider: dividend and divisor widths
  localparam int DIV_W = 27;
  localparam int DVS_W = 15;

  // Serial multiplier: wide operand, serial operand, product
  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 8;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Duty conversion constants
  localparam logic [DUTY_W-1:0] DUTY_FULL = 12'd4095;
  localparam logic [DVS_W-1:0]  PERIOD_US = 15'd20000;

  // Register reset values
  localparam logic [11:0] LIGHT_LOW_RST  = 12'd50;
  localparam logic [11:0] LIGHT_HIGH_RST = 12'd3000;
  localparam logic [7:0]  ANGLE_LOW_RST  = 8'd10;
  localparam logic [7:0]  ANGLE_HIGH_RST = 8'd170;
  localparam logic [14:0] PULSE_LOW_RST  = 15'd500;
  localparam logic [14:0] PULSE_HIGH_RST = 15'd2500;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LIGHT_LOW  = 3'd0,
    REG_LIGHT_HIGH = 3'd1,
    REG_ANGLE_LOW  = 3'd2,
    REG_ANGLE_HIGH = 3'd3,
    REG_PULSE_LOW  = 3'd4,
    REG_PULSE_HIGH = 3'd5
  } cfg_reg_t;

  // Ring buffer control from the sequencer
  typedef struct packed {
    logic rd;   // read the slot about to be overwritten
    logic upd;  // write the sample, update sum and count
  } ring_ctl_t;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Multiplier request
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Clamp: below lo gives lo, above hi gives hi
  function automatic logic [11:0] clamp_val(input logic [11:0] v, input logic [11:0] lo,
                                            input logic [11:0] hi);
    logic [11:0] res;
    if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== src/mvsd_ring.sv =====
// Sample ring buffer with running sum and fill count.
module mvsd_ring #(
  parameter int WINDOW = mvsd_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mvsd_pkg::ring_ctl_t       ctl,
  input  logic [mvsd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [$clog2(WINDOW*mvsd_pkg::SAMPLE_MAX+1)-1:0] sum_o,
  output logic [$clog2(WINDOW+1)-1:0] count_o
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * mvsd_pkg::SAMPLE_MAX + 1);

  logic [mvsd_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [mvsd_pkg::SAMPLE_W-1:0] rd_r;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic                          full;

  // Next slot, count and sum
  always_comb begin
    full      = (count_r == CNT_W'(WINDOW));
    slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
    count_nxt = full ? count_r : count_r + 1'b1;
    if (full) begin
      sum_nxt = sum_r - SUM_W'(rd_r) + SUM_W'(sample_i);
    end else begin
      sum_nxt = sum_r + SUM_W'(sample_i);
    end
  end

  // Memory: registered read, write on update
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_r <= mem[slot_r];
    end
    if (ctl.upd) begin
      mem[slot_r] <= sample_i;
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else if (ctl.upd) begin
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign sum_o   = sum_r;
  assign count_o = count_r;

endmodule

// ===== src/mvsd_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module mvsd_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mvsd_pkg::mul_req_t            req,
  output logic                          done_o,
  output logic [mvsd_pkg::MUL_P_W-1:0]  prod_o
);

  localparam int CNT_W = (mvsd_pkg::MUL_B_W > 1) ? $clog2(mvsd_pkg::MUL_B_W) : 1;

  logic [mvsd_pkg::MUL_P_W-1:0] a_r;
  logic [mvsd_pkg::MUL_B_W-1:0] b_r;
  logic [mvsd_pkg::MUL_P_W-1:0] acc_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses the cycle after the last step
      done_r <= !req.start && busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mvsd_pkg::MUL_B_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: add shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= mvsd_pkg::MUL_P_W'(req.a);
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[mvsd_pkg::MUL_P_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[mvsd_pkg::MUL_B_W-1:1]};
    end
  end

  assign done_o = done_r;
  assign prod_o = acc_r;

endmodule

// ===== src/mvsd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module mvsd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mvsd_pkg::div_req_t          req,
  output logic                        done_o,
  output logic [mvsd_pkg::DIV_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(mvsd_pkg::DIV_W);

  logic [mvsd_pkg::DIV_W-1:0] quo_r;
  logic [mvsd_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [mvsd_pkg::DVS_W-1:0] dvs_r;
  logic [mvsd_pkg::DVS_W:0]   trial, diff;
  logic                       ge;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  // One restoring step
  always_comb begin
    trial   = {rem_r, quo_r[mvsd_pkg::DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[mvsd_pkg::DVS_W-1:0] : trial[mvsd_pkg::DVS_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Done pulses the cycle after the last step
      done_r <= !req.start && busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mvsd_pkg::DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[mvsd_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

// ===== src/moving_average_to_servo_duty.sv =====
// Sequence per input transaction: four serial divisions (average, two maps, duty),
//   two serial multiplies and sequencing; fewer steps when map bounds are equal.
// Samples are handled one at a time through the shared bit-serial divider; the next is accepted
//   once a result is loaded, also while a finished result waits in the output register.
// Reset (rst_n low, synchronous): registers return to defaults, window empties, output drops.
// The ring memory is not cleared; an entry is only used once it has been written.
module moving_average_to_servo_duty #(
  parameter int WINDOW = mvsd_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mvsd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [11:0] sample_mv
  // Output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mvsd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [11:0] average_mv, [19:12] angle_deg,
                                                          // [34:20] pulse_us, [46:35] duty_value
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [mvsd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mvsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = $clog2(WINDOW * mvsd_pkg::SAMPLE_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_SUM, S_AVG, S_M1, S_MUL, S_DIV, S_M2, S_DUTY, S_DUTYW, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [11:0] light_lo_r, light_hi_r;
  logic [7:0]  ang_lo_r, ang_hi_r;
  logic [14:0] pls_lo_r, pls_hi_r;

  // Datapath registers
  logic [mvsd_pkg::SAMPLE_W-1:0] sample_r;
  logic [mvsd_pkg::SAMPLE_W-1:0] avg_r;
  logic [mvsd_pkg::ANGLE_W-1:0]  deg_r;
  logic [mvsd_pkg::PULSE_W-1:0]  us_r;
  logic [mvsd_pkg::DUTY_W-1:0]   duty_r;
  logic [14:0]                   base_r;
  logic [mvsd_pkg::DVS_W-1:0]    den_r;
  logic                          neg_r;
  logic                          phase_r;
  logic                          out_tvalid_r;
  logic [mvsd_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  // Unit requests
  logic                         div_start_r, mul_start_r;
  logic [mvsd_pkg::DIV_W-1:0]   div_a_r;
  logic [mvsd_pkg::DVS_W-1:0]   div_b_r;
  logic [mvsd_pkg::MUL_A_W-1:0] mul_a_r;
  logic [mvsd_pkg::MUL_B_W-1:0] mul_b_r;

  mvsd_pkg::ring_ctl_t ring_ctl;
  mvsd_pkg::div_req_t  div_req;
  mvsd_pkg::mul_req_t  mul_req;
  logic [SUM_W-1:0]             ring_sum;
  logic [CNT_W-1:0]             ring_cnt;
  logic                         div_done, mul_done;
  logic [mvsd_pkg::DIV_W-1:0]   div_quo;
  logic [mvsd_pkg::MUL_P_W-1:0] mul_prod;

  // Map 1 set-up: light level to angle
  logic [11:0] lvl1;
  logic [12:0] dv1, dv1_neg, din1, din1_neg;
  logic [8:0]  dout1, dout1_neg;
  logic [11:0] dv1_mag, din1_mag;
  logic [7:0]  dout1_mag;

  // Map 2 set-up: angle to pulse width
  logic [11:0] v2_wide;
  logic [7:0]  v2;
  logic [8:0]  dv2, dv2_neg, din2, din2_neg;
  logic [15:0] dout2, dout2_neg;
  logic [7:0]  dv2_mag, din2_mag;
  logic [14:0] dout2_mag;

  // Map finish and duty
  logic [16:0] q17, map_sum;
  logic [mvsd_pkg::DIV_W-1:0] duty_num;

  always_comb begin
    lvl1      = mvsd_pkg::clamp_val(mvsd_pkg::clamp_val(avg_r, light_lo_r, light_hi_r),
                                    light_lo_r, light_hi_r);
    dv1       = {1'b0, lvl1} - {1'b0, light_lo_r};
    dv1_neg   = -dv1;
    dv1_mag   = dv1[12] ? dv1_neg[11:0] : dv1[11:0];
    din1      = {1'b0, light_hi_r} - {1'b0, light_lo_r};
    din1_neg  = -din1;
    din1_mag  = din1[12] ? din1_neg[11:0] : din1[11:0];
    dout1     = {1'b0, ang_hi_r} - {1'b0, ang_lo_r};
    dout1_neg = -dout1;
    dout1_mag = dout1[8] ? dout1_neg[7:0] : dout1[7:0];

    v2_wide   = mvsd_pkg::clamp_val({4'b0, deg_r}, {4'b0, ang_lo_r}, {4'b0, ang_hi_r});
    v2        = v2_wide[7:0];
    dv2       = {1'b0, v2} - {1'b0, ang_lo_r};
    dv2_neg   = -dv2;
    dv2_mag   = dv2[8] ? dv2_neg[7:0] : dv2[7:0];
    din2      = {1'b0, ang_hi_r} - {1'b0, ang_lo_r};
    din2_neg  = -din2;
    din2_mag  = din2[8] ? din2_neg[7:0] : din2[7:0];
    dout2     = {1'b0, pls_hi_r} - {1'b0, pls_lo_r};
    dout2_neg = -dout2;
    dout2_mag = dout2[15] ? dout2_neg[14:0] : dout2[14:0];

    // Quotient is bounded by the output span, so 16 bits carry it
    q17      = {1'b0, div_quo[15:0]};
    map_sum  = neg_r ? ({2'b0, base_r} - q17) : ({2'b0, base_r} + q17);

    // 4095 * us as (us << 12) - us
    duty_num = {us_r, 12'b0} - mvsd_pkg::DIV_W'(us_r);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_lo_r <= mvsd_pkg::LIGHT_LOW_RST;
      light_hi_r <= mvsd_pkg::LIGHT_HIGH_RST;
      ang_lo_r   <= mvsd_pkg::ANGLE_LOW_RST;
      ang_hi_r   <= mvsd_pkg::ANGLE_HIGH_RST;
      pls_lo_r   <= mvsd_pkg::PULSE_LOW_RST;
      pls_hi_r   <= mvsd_pkg::PULSE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mvsd_pkg::REG_LIGHT_LOW:  light_lo_r <= cfg_wdata[11:0];
        mvsd_pkg::REG_LIGHT_HIGH: light_hi_r <= cfg_wdata[11:0];
        mvsd_pkg::REG_ANGLE_LOW:  ang_lo_r   <= cfg_wdata[7:0];
        mvsd_pkg::REG_ANGLE_HIGH: ang_hi_r   <= cfg_wdata[7:0];
        mvsd_pkg::REG_PULSE_LOW:  pls_lo_r   <= cfg_wdata[14:0];
        mvsd_pkg::REG_PULSE_HIGH: pls_hi_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      div_start_r  <= 1'b0;
      mul_start_r  <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      // Unit start pulses follow the step that sets up the operands
      div_start_r <= (state_r == S_SUM) || ((state_r == S_MUL) && mul_done) ||
                     (state_r == S_DUTY);
      mul_start_r <= ((state_r == S_M1) && (light_lo_r != light_hi_r)) ||
                     ((state_r == S_M2) && (ang_lo_r != ang_hi_r));
      // Output drains here unless a new result is loaded in the same cycle
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata[mvsd_pkg::SAMPLE_W-1:0];
            state_r  <= S_RING;
          end
        end
        S_RING: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          div_a_r     <= mvsd_pkg::DIV_W'(ring_sum);
          div_b_r     <= mvsd_pkg::DVS_W'(ring_cnt);
          state_r     <= S_AVG;
        end
        S_AVG: begin
          if (div_done) begin
            avg_r   <= div_quo[mvsd_pkg::SAMPLE_W-1:0];
            state_r <= S_M1;
          end
        end
        S_M1: begin
          if (light_lo_r == light_hi_r) begin
            deg_r   <= ang_hi_r;
            state_r <= S_M2;
          end else begin
            mul_a_r     <= mvsd_pkg::MUL_A_W'(dv1_mag);
            mul_b_r     <= dout1_mag;
            den_r       <= mvsd_pkg::DVS_W'(din1_mag);
            neg_r       <= dv1[12] ^ dout1[8] ^ din1[12];
            base_r      <= 15'(ang_lo_r);
            phase_r     <= 1'b0;
            state_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_a_r     <= mvsd_pkg::DIV_W'(mul_prod);
            div_b_r     <= den_r;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!phase_r) begin
              deg_r   <= map_sum[mvsd_pkg::ANGLE_W-1:0];
              state_r <= S_M2;
            end else begin
              us_r    <= map_sum[mvsd_pkg::PULSE_W-1:0];
              state_r <= S_DUTY;
            end
          end
        end
        S_M2: begin
          if (ang_lo_r == ang_hi_r) begin
            us_r    <= pls_hi_r;
            state_r <= S_DUTY;
          end else begin
            mul_a_r     <= dout2_mag;
            mul_b_r     <= dv2_mag;
            den_r       <= mvsd_pkg::DVS_W'(din2_mag);
            neg_r       <= dv2[8] ^ dout2[15] ^ din2[8];
            base_r      <= pls_lo_r;
            phase_r     <= 1'b1;
            state_r     <= S_MUL;
          end
        end
        S_DUTY: begin
          div_a_r     <= duty_num;
          div_b_r     <= mvsd_pkg::PERIOD_US;
          state_r     <= S_DUTYW;
        end
        S_DUTYW: begin
          if (div_done) begin
            // Saturate for pulse settings above the period
            if (div_quo > mvsd_pkg::DIV_W'(mvsd_pkg::DUTY_FULL)) begin
              duty_r <= mvsd_pkg::DUTY_FULL;
            end else begin
              duty_r <= div_quo[mvsd_pkg::DUTY_W-1:0];
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {1'b0, duty_r, us_r, deg_r, avg_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Unit hookup
  assign ring_ctl.rd  = (state_r == S_IDLE) && in_tvalid;
  assign ring_ctl.upd = (state_r == S_RING);

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_a_r;
  assign div_req.divisor  = div_b_r;

  assign mul_req.start = mul_start_r;
  assign mul_req.a     = mul_a_r;
  assign mul_req.b     = mul_b_r;

  mvsd_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .sample_i (sample_r),
    .sum_o    (ring_sum),
    .count_o  (ring_cnt)
  );

  mvsd_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  mvsd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
